/* rtl/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

   // Error codes carried in a result beat.
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_CONT      = 3'd1,
      ERR_OVERLONG  = 3'd2,
      ERR_SURROGATE = 3'd3,
      ERR_RANGE     = 3'd4,
      ERR_LEAD      = 3'd5
   } error_type;

   // One input beat: a raw UTF-8 byte and the end-of-string flag.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_string;
   } req_beat_type;

   // One result beat: a UTF-16 unit or surrogate half, its status and last flag.
   typedef struct packed {
      logic [15:0] unit_out;
      error_type   error_code;
      logic        last_result;
   } rsp_beat_type;

   // A decoded event queued between the front and back ends.
   typedef struct packed {
      logic [20:0] code_point;
      error_type   error_code;
      logic        last_result;
   } event_type;

   localparam logic [20:0] CP_TWO_BYTE_MIN   = 21'h000080;
   localparam logic [20:0] CP_THREE_BYTE_MIN = 21'h000800;
   localparam logic [20:0] CP_SURR_LO        = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI        = 21'h00DFFF;
   localparam logic [20:0] CP_SUPPLEMENTARY  = 21'h010000;
   localparam logic [20:0] CP_MAX            = 21'h10FFFF;
   localparam logic [5:0]  HIGH_SURR_TAG     = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG      = 6'b110111;

endpackage

/* rtl/utf8_to_utf16_validating_decoder.sv */
// UTF-8 to UTF-16 validating decoder, top level.
// Takes one UTF-8 byte per cycle and gives back UTF-16 code units on the result
// channel, one beat per cycle while rsp_ready is high. A byte is taken in the same
// cycle it arrives while the event queue (QUEUE_DEPTH entries) has room; the front
// end finishes the byte's decoding in that cycle. A code point at or above U+10000
// leaves as two consecutive beats, high surrogate first; only the low one carries
// last_result. A malformed string yields one beat with unit_out zero, a nonzero
// error_code and last_result set, after which bytes are dropped up to the
// end-of-string byte.
module utf8_to_utf16_validating_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  u8u16_pkg::req_beat_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output u8u16_pkg::rsp_beat_type rsp_data
);
   import u8u16_pkg::*;

   event_type push_data, pop_data;
   logic      push, full, pop, empty;

   u8u16_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .evt_push  (push),
      .evt_data  (push_data),
      .evt_full  (full)
   );

   u8u16_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   u8u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_data  (pop_data),
      .evt_empty (empty),
      .evt_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/u8u16_front.sv */
// Front end: accepts UTF-8 bytes, tracks sequences and classifies finished code points.
module u8u16_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  u8u16_pkg::req_beat_type req_data,
   output logic                    evt_push,
   output u8u16_pkg::event_type    evt_data,
   input  logic                    evt_full
);
   import u8u16_pkg::*;

   logic [1:0]  pending_ff, pending_in;
   logic [1:0]  seq_len_ff, seq_len_in;
   logic [20:0] acc_ff, acc_in;
   logic        discard_ff, discard_in;
   logic        accept;
   logic [7:0]  b;
   logic        eos;
   logic [20:0] acc_next;
   logic [1:0]  pending_dec;

   assign req_ready   = !evt_full;
   assign accept      = req_valid && req_ready;
   assign b           = req_data.byte_in;
   assign eos         = req_data.end_of_string;
   assign acc_next    = {acc_ff[14:0], b[5:0]};
   assign pending_dec = pending_ff - 2'd1;

   // Decode one byte: update the sequence state and decide what to queue.
   always_comb begin
      pending_in = pending_ff;
      seq_len_in = seq_len_ff;
      acc_in     = acc_ff;
      discard_in = discard_ff;
      evt_push   = 1'b0;
      evt_data   = '{code_point: 21'd0, error_code: ERR_NONE, last_result: eos};

      if (accept) begin
         if (discard_ff) begin
            // After an error, bytes are dropped until the string ends.
            if (eos) begin
               discard_in = 1'b0;
               pending_in = 2'd0;
               seq_len_in = 2'd0;
               acc_in     = 21'd0;
            end
         end else if (pending_ff == 2'd0) begin
            // Expecting a lead byte.
            if (!b[7]) begin
               evt_push            = 1'b1;
               evt_data.code_point = {13'd0, b};
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
               if (b[7:5] == 3'b110) begin
                  acc_in     = {16'd0, b[4:0]};
                  seq_len_in = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  acc_in     = {17'd0, b[3:0]};
                  seq_len_in = 2'd2;
               end else begin
                  acc_in     = {18'd0, b[2:0]};
                  seq_len_in = 2'd3;
               end
               pending_in = seq_len_in;
               if (eos) begin
                  // The string ends right after a lead byte.
                  evt_push            = 1'b1;
                  evt_data.error_code = ERR_CONT;
                  evt_data.last_result = 1'b1;
                  pending_in = 2'd0;
                  seq_len_in = 2'd0;
                  acc_in     = 21'd0;
               end
            end else begin
               evt_push             = 1'b1;
               evt_data.error_code  = ERR_LEAD;
               evt_data.last_result = 1'b1;
               discard_in           = !eos;
            end
         end else if (b[7:6] != 2'b10) begin
            // A continuation byte was expected.
            evt_push             = 1'b1;
            evt_data.error_code  = ERR_CONT;
            evt_data.last_result = 1'b1;
            discard_in           = !eos;
            pending_in           = 2'd0;
            seq_len_in           = 2'd0;
            acc_in               = 21'd0;
         end else if (pending_dec != 2'd0) begin
            acc_in     = acc_next;
            pending_in = pending_dec;
            if (eos) begin
               // The string ends inside a sequence.
               evt_push             = 1'b1;
               evt_data.error_code  = ERR_CONT;
               evt_data.last_result = 1'b1;
               pending_in           = 2'd0;
               seq_len_in           = 2'd0;
               acc_in               = 21'd0;
            end
         end else begin
            // Sequence complete: range checks by sequence length.
            pending_in          = 2'd0;
            seq_len_in          = 2'd0;
            acc_in              = 21'd0;
            evt_push            = 1'b1;
            evt_data.code_point = acc_next;
            case (seq_len_ff)
               2'd1: begin
                  if (acc_next < CP_TWO_BYTE_MIN) evt_data.error_code = ERR_OVERLONG;
               end
               2'd2: begin
                  if (acc_next < CP_THREE_BYTE_MIN) begin
                     evt_data.error_code = ERR_OVERLONG;
                  end else if (acc_next inside {[CP_SURR_LO:CP_SURR_HI]}) begin
                     evt_data.error_code = ERR_SURROGATE;
                  end
               end
               default: begin
                  if (acc_next < CP_SUPPLEMENTARY || acc_next > CP_MAX)
                     evt_data.error_code = ERR_RANGE;
               end
            endcase
            if (evt_data.error_code != ERR_NONE) begin
               evt_data.code_point  = 21'd0;
               evt_data.last_result = 1'b1;
               discard_in           = !eos;
            end
         end
      end
   end

   // Sequence state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         seq_len_ff <= 2'd0;
         acc_ff     <= 21'd0;
         discard_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         seq_len_ff <= seq_len_in;
         acc_ff     <= acc_in;
         discard_ff <= discard_in;
      end
   end

endmodule

/* rtl/u8u16_queue.sv */
// Small first-in first-out queue of decoded events between front and back ends.
module u8u16_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u8u16_pkg::event_type push_data,
   output logic                 full,
   input  logic                 pop,
   output u8u16_pkg::event_type pop_data,
   output logic                 empty
);
   import u8u16_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   event_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* rtl/u8u16_back.sv */
// Back end: turns queued events into UTF-16 result beats, splitting surrogate pairs.
module u8u16_back (
   input  logic                    clock,
   input  logic                    reset,
   input  u8u16_pkg::event_type    evt_data,
   input  logic                    evt_empty,
   output logic                    evt_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output u8u16_pkg::rsp_beat_type rsp_data
);
   import u8u16_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_data_ff, rsp_data_in;
   logic         low_pend_ff, low_pend_in;
   logic [9:0]   low_bits_ff, low_bits_in;
   logic         low_last_ff, low_last_in;
   logic         load;
   logic [20:0]  offset;

   assign load      = !rsp_valid_ff || rsp_ready;
   assign offset    = evt_data.code_point - CP_SUPPLEMENTARY;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Pick the next beat: a pending low surrogate first, then the queue head.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      low_pend_in  = low_pend_ff;
      low_bits_in  = low_bits_ff;
      low_last_in  = low_last_ff;
      evt_pop      = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b0;
         if (low_pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{unit_out: {LOW_SURR_TAG, low_bits_ff},
                             error_code: ERR_NONE, last_result: low_last_ff};
            low_pend_in  = 1'b0;
         end else if (!evt_empty) begin
            evt_pop      = 1'b1;
            rsp_valid_in = 1'b1;
            if (evt_data.error_code != ERR_NONE) begin
               rsp_data_in = '{unit_out: 16'd0, error_code: evt_data.error_code,
                               last_result: 1'b1};
            end else if (evt_data.code_point < CP_SUPPLEMENTARY) begin
               rsp_data_in = '{unit_out: evt_data.code_point[15:0], error_code: ERR_NONE,
                               last_result: evt_data.last_result};
            end else begin
               rsp_data_in = '{unit_out: {HIGH_SURR_TAG, offset[19:10]},
                               error_code: ERR_NONE, last_result: 1'b0};
               low_pend_in = 1'b1;
               low_bits_in = offset[9:0];
               low_last_in = evt_data.last_result;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         low_pend_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         low_pend_ff  <= low_pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      low_bits_ff <= low_bits_in;
      low_last_ff <= low_last_in;
   end

endmodule

/* rtl/u8u16_checker.sv */
// Port-level assertions for the decoder, bound to the top level.
module u8u16_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input u8u16_pkg::rsp_beat_type rsp_data
);
   import u8u16_pkg::*;

   // An error beat always closes the string and carries no unit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_NONE
         |-> rsp_data.last_result && rsp_data.unit_out == 16'd0)
      else $error("error beat without last flag or with nonzero unit");

   // A high surrogate never ends a string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unit_out[15:10] == HIGH_SURR_TAG |-> !rsp_data.last_result)
      else $error("high surrogate marked last");

   // A taken high surrogate is followed at once by its low surrogate.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.unit_out[15:10] == HIGH_SURR_TAG
         |=> rsp_valid && rsp_data.unit_out[15:10] == LOW_SURR_TAG
             && rsp_data.error_code == ERR_NONE)
      else $error("high surrogate not followed by low surrogate");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

endmodule

bind utf8_to_utf16_validating_decoder u8u16_checker u_checker (.*);

/* test/utf8_to_utf16_validating_decoder_tb.sv */
// Self-checking testbench for the UTF-8 to UTF-16 validating decoder.
`timescale 1ns / 1ps

module utf8_to_utf16_validating_decoder_tb;
   import u8u16_pkg::*;

   localparam int RANDOM_ITEMS = 750;
   localparam int HOLD_CYCLES  = 200;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   // One row of the directed stimulus; a pinned row carries its one result typed in.
   typedef struct packed {
      logic [7:0]   b;
      logic         eos;
      logic         pinned;
      rsp_beat_type want;
   } directed_row_type;

   // Travels with each offered byte so the monitor knows whether its result is pinned.
   typedef struct packed {
      logic         pinned;
      rsp_beat_type want;
   } pin_note_type;

   localparam rsp_beat_type NO_UNIT = '0;

   localparam directed_row_type DIRECTED_ROWS [27] = '{
      {8'h00, 1'b1, 1'b1, 16'h0000, ERR_NONE, 1'b1},
      {8'h7F, 1'b0, 1'b1, 16'h007F, ERR_NONE, 1'b0},
      {8'hC2, 1'b0, 1'b0, NO_UNIT},
      {8'h80, 1'b1, 1'b0, NO_UNIT},
      {8'hF4, 1'b0, 1'b0, NO_UNIT},
      {8'h8F, 1'b0, 1'b0, NO_UNIT},
      {8'hBF, 1'b0, 1'b0, NO_UNIT},
      {8'hBF, 1'b1, 1'b0, NO_UNIT},
      {8'hC0, 1'b0, 1'b0, NO_UNIT},
      {8'h80, 1'b1, 1'b1, 16'h0000, ERR_OVERLONG, 1'b1},
      {8'hED, 1'b0, 1'b0, NO_UNIT},
      {8'hA0, 1'b0, 1'b0, NO_UNIT},
      {8'h80, 1'b1, 1'b1, 16'h0000, ERR_SURROGATE, 1'b1},
      {8'hF4, 1'b0, 1'b0, NO_UNIT},
      {8'h90, 1'b0, 1'b0, NO_UNIT},
      {8'h80, 1'b0, 1'b0, NO_UNIT},
      {8'h80, 1'b1, 1'b1, 16'h0000, ERR_RANGE, 1'b1},
      {8'hFF, 1'b0, 1'b1, 16'h0000, ERR_LEAD, 1'b1},
      {8'h41, 1'b1, 1'b0, NO_UNIT},
      {8'hC3, 1'b1, 1'b1, 16'h0000, ERR_CONT, 1'b1},
      {8'hE2, 1'b0, 1'b0, NO_UNIT},
      {8'h41, 1'b0, 1'b1, 16'h0000, ERR_CONT, 1'b1},
      {8'h80, 1'b1, 1'b0, NO_UNIT},
      {8'hF0, 1'b0, 1'b0, NO_UNIT},
      {8'h8F, 1'b0, 1'b0, NO_UNIT},
      {8'hBF, 1'b0, 1'b0, NO_UNIT},
      {8'hBF, 1'b1, 1'b1, 16'h0000, ERR_RANGE, 1'b1}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_data;

   // Decoder model state.
   logic [1:0]  cont_left = '0;
   logic [1:0]  cont_total = '0;
   logic [20:0] partial_cp = '0;
   logic        skipping = 1'b0;

   rsp_beat_type expected_units [$];
   pin_note_type pin_notes [$];
   logic [7:0]   str_bytes [$];

   int mismatches = 0;
   int bytes_in = 0;
   int useful_in = 0;
   int units_out = 0;
   int error_units = 0;
   int surrogate_pairs = 0;
   int idle_cycles = 0;
   int burst_left = 1;
   int held_cycles = 0;
   bit flood_started = 1'b0;

   utf8_to_utf16_validating_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Appends one unit to the expected sequence.
   function automatic void expect_unit(input rsp_beat_type u);
      expected_units = {expected_units, u};
   endfunction

   // Appends one byte to the string being built.
   function automatic void add_byte(input logic [7:0] v);
      str_bytes = {str_bytes, v};
   endfunction

   function automatic void clear_sequence();
      cont_left = '0;
      cont_total = '0;
      partial_cp = '0;
   endfunction

   // A malformed sequence gives one error unit; the rest of the string is dropped
   // unless the error fell on its last byte.
   function automatic void reject_sequence(input error_type e, input logic eos);
      clear_sequence();
      skipping = !eos;
      expect_unit({16'h0000, e, 1'b1});
   endfunction

   // Code points above the basic plane split into a high and a low surrogate.
   function automatic void emit_code_point(input logic [20:0] cp, input logic eos);
      logic [19:0] offset;
      if (cp < CP_SUPPLEMENTARY) begin
         expect_unit({cp[15:0], ERR_NONE, eos});
      end else begin
         offset = 20'(cp - CP_SUPPLEMENTARY);
         expect_unit({HIGH_SURR_TAG, offset[19:10], ERR_NONE, 1'b0});
         expect_unit({LOW_SURR_TAG, offset[9:0], ERR_NONE, eos});
      end
   endfunction

   // Advances the decoder model by one byte and queues the units it produces.
   function automatic void decode_byte(input logic [7:0] b, input logic eos);
      logic [20:0] cp;
      logic [1:0]  len;
      if (skipping) begin
         if (eos) begin
            skipping = 1'b0;
            clear_sequence();
         end
         return;
      end

      // Lead byte.
      if (cont_left == 2'd0) begin
         if (!b[7]) begin
            emit_code_point({13'd0, b}, eos);
            return;
         end
         if (b[7:5] == 3'b110) begin
            partial_cp = {16'd0, b[4:0]};
            cont_total = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            partial_cp = {17'd0, b[3:0]};
            cont_total = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            partial_cp = {18'd0, b[2:0]};
            cont_total = 2'd3;
         end else begin
            reject_sequence(ERR_LEAD, eos);
            return;
         end
         cont_left = cont_total;
         if (eos) reject_sequence(ERR_CONT, eos);
         return;
      end

      // Continuation byte.
      if (b[7:6] != 2'b10) begin
         reject_sequence(ERR_CONT, eos);
         return;
      end
      partial_cp = {partial_cp[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left != 2'd0) begin
         if (eos) reject_sequence(ERR_CONT, eos);
         return;
      end

      // Sequence complete: check the value against its encoded length.
      cp = partial_cp;
      len = cont_total;
      clear_sequence();
      if (len == 2'd1) begin
         if (cp < CP_TWO_BYTE_MIN) begin
            reject_sequence(ERR_OVERLONG, eos);
            return;
         end
      end else if (len == 2'd2) begin
         if (cp < CP_THREE_BYTE_MIN) begin
            reject_sequence(ERR_OVERLONG, eos);
            return;
         end
         if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
            reject_sequence(ERR_SURROGATE, eos);
            return;
         end
      end else if (cp < CP_SUPPLEMENTARY || cp > CP_MAX) begin
         reject_sequence(ERR_RANGE, eos);
         return;
      end
      emit_code_point(cp, eos);
   endfunction

   // Appends the UTF-8 form of a value at a forced length, so overlong forms come out too.
   function automatic void append_encoded(input logic [20:0] cp, input int n);
      case (n)
         1: begin
            add_byte({1'b0, cp[6:0]});
         end
         2: begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input rsp_beat_type want,
                                  input rsp_beat_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected unit %h err %0d last %b, got unit %h err %0d last %b",
                  $time, what, want.unit_out, want.error_code, want.last_result,
                  got.unit_out, got.error_code, got.last_result);
   endtask

   // Holds one byte on the input channel until it is taken.
   task automatic offer_byte(input logic [7:0] b, input logic eos, input logic pinned,
                             input rsp_beat_type want);
      pin_note_type note;
      note = '{pinned: pinned, want: want};
      pin_notes = {pin_notes, note};
      req_valid <= 1'b1;
      req_data <= {b, eos};
      do @(posedge clock); while (!req_ready);
   endtask

   // Sender bursts: after each burst the input goes idle before the next burst.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Both channels are observed at the clock edge; accepted bytes feed the model,
   // accepted units are checked against the oldest expectation.
   always @(posedge clock) begin : watch_channels
      logic         took;
      pin_note_type note;
      int           queued_before;
      rsp_beat_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         took = 1'b0;
         if (req_valid && req_ready) begin
            took = 1'b1;
            bytes_in++;
            if (!skipping) useful_in++;
            note = pin_notes.pop_front();
            queued_before = expected_units.size();
            decode_byte(req_data.byte_in, req_data.end_of_string);
            if (note.pinned) begin
               while (expected_units.size() > queued_before)
                  void'(expected_units.pop_back());
               expect_unit(note.want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            took = 1'b1;
            units_out++;
            if (rsp_data.error_code != ERR_NONE) error_units++;
            if (rsp_data.error_code == ERR_NONE && rsp_data.unit_out[15:10] == LOW_SURR_TAG)
               surrogate_pairs++;
            if (expected_units.size() == 0) begin
               report_mismatch("unit with none pending", NO_UNIT, rsp_data);
            end else begin
               want = expected_units.pop_front();
               if (rsp_data.unit_out !== want.unit_out ||
                   rsp_data.error_code !== want.error_code ||
                   rsp_data.last_result !== want.last_result)
                  report_mismatch("wrong unit", want, rsp_data);
            end
         end
         if (took) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles, %0d units pending",
                     IDLE_LIMIT, expected_units.size());
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver: stall patterns in segments, plus one long hold-off once random traffic runs.
   initial begin : receiver
      int mode;
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (flood_started && held_cycles == 0) begin
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_ready <= 1'b0;
               held_cycles++;
            end
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= !rsp_ready;
            endcase
         end
      end
   end

   // Sender: reset, directed rows, then random strings of mostly well-formed text.
   initial begin : sender
      int          chars;
      int          pick;
      int          n;
      int          k;
      int          strings_sent;
      logic [20:0] cp;
      logic [7:0]  b;
      strings_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         offer_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].eos, DIRECTED_ROWS[i].pinned,
                    DIRECTED_ROWS[i].want);
         pace_sender();
      end

      flood_started = 1'b1;
      while (bytes_in < $size(DIRECTED_ROWS) + RANDOM_ITEMS) begin
         str_bytes.delete();
         chars = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
         for (int c = 0; c < chars; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               append_encoded(21'($urandom_range(0, 'h7F)), 1);
            end else if (pick < 50) begin
               append_encoded(21'($urandom_range('h80, 'h7FF)), 2);
            end else if (pick < 70) begin
               // Three-byte values with the surrogate range skipped.
               cp = 21'($urandom_range('h800, 'hF7FF));
               if (cp >= CP_SURR_LO) cp = cp + 21'h800;
               append_encoded(cp, 3);
            end else if (pick < 85) begin
               append_encoded(21'($urandom_range('h10000, 'h10FFFF)), 4);
            end else if (pick < 88) begin
               // Overlong: a value that fits a shorter form.
               n = $urandom_range(2, 4);
               cp = 21'($urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF));
               append_encoded(cp, n);
            end else if (pick < 90) begin
               append_encoded(21'($urandom_range('hD800, 'hDFFF)), 3);
            end else if (pick < 92) begin
               append_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            end else if (pick < 94) begin
               b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range('h80, 'hBF))
                                               : 8'($urandom_range('hF8, 'hFF));
               add_byte(b);
            end else if (pick < 97) begin
               // One continuation byte replaced by something that is not one.
               n = $urandom_range(2, 4);
               append_encoded(21'($urandom_range(0, 'h1FFFFF)), n);
               k = $urandom_range(1, n - 1);
               b = 8'($urandom_range(0, 255));
               if (b[7:6] == 2'b10) b[6] = 1'b1;
               str_bytes[str_bytes.size() - k] = b;
            end else if (pick < 98) begin
               // Truncated sequence.
               n = $urandom_range(2, 4);
               append_encoded(21'($urandom_range(0, 'h1FFFFF)), n);
               k = $urandom_range(1, n - 1);
               repeat (k) void'(str_bytes.pop_back());
            end else begin
               add_byte(8'($urandom_range(0, 255)));
            end
         end
         foreach (str_bytes[i]) begin
            offer_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, NO_UNIT);
            pace_sender();
         end
         strings_sent++;
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray units.
      while (expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes (%0d decoded) in %0d random strings plus directed rows; got %0d units",
               bytes_in, useful_in, strings_sent, units_out);
      $display("  %0d error units, %0d surrogate pairs, %0d-cycle receiver hold, %0d mismatches",
               error_units, surrogate_pairs, held_cycles, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
